>>> hw/rtl/qrot_pkg.sv
// qrot_pkg: shared constants for the quaternion rotation core.
// Default widths, register indexes and reset values; no dependencies.
package qrot_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int ROT_WIDTH_DEF  = 18;
	localparam int CFG_ADDR_W     = 2;

	localparam logic [CFG_ADDR_W-1:0] REG_ROT_R = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_ROT_I = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_ROT_J = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_ROT_K = 2'd3;

	// 1.0 in Q2.16
	localparam logic [63:0] ROT_R_RESET = 64'd65536;

endpackage

>>> hw/rtl/qrot_hamilton.sv
// qrot_hamilton: two-stage pipelined Hamilton product z = a * b.
// Stage 1 registers the sixteen partial products, stage 2 the sums. Uses no package items.
module qrot_hamilton #(
	parameter int AW = 18,
	parameter int BW = 32,
	parameter int ZW = AW + BW + 2
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] a [4],
	input  logic signed [BW-1:0] b [4],
	output logic signed [ZW-1:0] z [4]
);

	logic signed [AW+BW-1:0] prod_s1 [4][4];
	logic signed [ZW-1:0]    z_s2 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					prod_s1[i][j] <= a[i] * b[j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s2[0] <= ZW'(prod_s1[0][0]) - ZW'(prod_s1[1][1])
				- ZW'(prod_s1[2][2]) - ZW'(prod_s1[3][3]);
			z_s2[1] <= ZW'(prod_s1[0][1]) + ZW'(prod_s1[1][0])
				+ ZW'(prod_s1[2][3]) - ZW'(prod_s1[3][2]);
			z_s2[2] <= ZW'(prod_s1[0][2]) + ZW'(prod_s1[2][0])
				+ ZW'(prod_s1[3][1]) - ZW'(prod_s1[1][3]);
			z_s2[3] <= ZW'(prod_s1[0][3]) + ZW'(prod_s1[3][0])
				+ ZW'(prod_s1[1][2]) - ZW'(prod_s1[2][1]);
		end
	end

	assign z = z_s2;

endmodule

>>> hw/rtl/qrot_div.sv
// qrot_div: pipelined rounding divide of one component by the squared norm.
// One quotient bit per stage, then saturation and sign. Uses no package items.
module qrot_div #(
	parameter int DW = 32,
	parameter int TW = 73,
	parameter int NW = 37
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [TW-1:0] t,
	input  logic        [NW-1:0] n,
	output logic        [DW-1:0] res,
	output logic                 clip
);

	localparam int CW = TW + 2;

	logic [CW-1:0] rem_s [DW+1];
	logic [DW-1:0] quo_s [DW+1];
	logic          neg_s [DW+1];
	logic          ovf_s [DW+1];
	logic [DW-1:0] res_q;
	logic          clip_q;

	logic          t_neg;
	logic [CW-1:0] t_mag;
	logic [CW-1:0] num;
	logic [CW-1:0] ovf_lim;

	// rounded |t|/n = floor((2|t| + n) / 2n)
	assign t_neg   = t[TW-1];
	assign t_mag   = t_neg ? CW'(-t) : CW'(t);
	assign num     = (t_mag << 1) + CW'(n);
	assign ovf_lim = CW'(n) << (DW + 1);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			quo_s[0] <= '0;
			neg_s[0] <= t_neg;
			ovf_s[0] <= num >= ovf_lim;
		end
	end

	for (genvar k = 1; k <= DW; k++) begin : g_bit
		localparam int B = DW - k;
		logic [CW-1:0] dsh;
		logic          ge;
		assign dsh = CW'(n) << (B + 1);
		assign ge  = rem_s[k-1] >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? rem_s[k-1] - dsh : rem_s[k-1];
				quo_s[k] <= quo_s[k-1] | (DW'(ge) << B);
				neg_s[k] <= neg_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	logic [DW-1:0] lim;
	logic          sat;
	logic [DW-1:0] mag;

	assign lim = neg_s[DW] ? (DW'(1) << (DW - 1)) : ((DW'(1) << (DW - 1)) - DW'(1));
	assign sat = ovf_s[DW] || (quo_s[DW] > lim);
	assign mag = sat ? lim : quo_s[DW];

	always_ff @(posedge clk) begin
		if (en) begin
			if (n == '0) begin
				res_q  <= '0;
				clip_q <= 1'b0;
			end else begin
				res_q  <= neg_s[DW] ? -mag : mag;
				clip_q <= sat;
			end
		end
	end

	assign res  = res_q;
	assign clip = clip_q;

endmodule

>>> hw/rtl/quaternion_rotate_core.sv
// quaternion_rotate_core: rotates q by the configured p, p*q*conj(p)/|p|^2.
// Depends on qrot_pkg, qrot_hamilton and qrot_div.
//
//  channel  signals                                   dir   beat
//  in       in_valid in_ready in_r in_i in_j in_k      in    one quaternion
//  out      out_valid out_ready out_r..out_k flags     out   one rotated quaternion
//  cfg      cfg_we cfg_addr cfg_wdata                  in    one register write
//
// One beat per cycle unless the output stalls; depth follows the bit-per-stage divider.
// arst_n clears the valid pipeline and loads p with the unit quaternion.
// A stalled output freezes every stage at once; in_ready tracks out_ready when out_valid.
module quaternion_rotate_core #(
	parameter int DATA_WIDTH = qrot_pkg::DATA_WIDTH_DEF,
	parameter int ROT_WIDTH  = qrot_pkg::ROT_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [DATA_WIDTH-1:0]         in_r,
	input  logic signed [DATA_WIDTH-1:0]         in_i,
	input  logic signed [DATA_WIDTH-1:0]         in_j,
	input  logic signed [DATA_WIDTH-1:0]         in_k,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [DATA_WIDTH-1:0]         out_r,
	output logic signed [DATA_WIDTH-1:0]         out_i,
	output logic signed [DATA_WIDTH-1:0]         out_j,
	output logic signed [DATA_WIDTH-1:0]         out_k,
	output logic                                 zero_norm,
	output logic                                 clipped,
	input  logic                                 cfg_we,
	input  logic [qrot_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [ROT_WIDTH-1:0]                 cfg_wdata
);

	localparam int RW  = ROT_WIDTH;
	localparam int DW  = DATA_WIDTH;
	localparam int MW  = RW + DW + 2;
	localparam int TW  = MW + RW + 3;
	localparam int NW  = 2 * RW + 1;
	localparam int LAT = DW + 6;

	logic signed [RW-1:0] rot_q [4];
	logic        [NW-1:0] norm_q;
	logic [LAT-1:0]       vld_q;
	logic                 en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0] <= qrot_pkg::ROT_R_RESET[RW-1:0];
			rot_q[1] <= '0;
			rot_q[2] <= '0;
			rot_q[3] <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				qrot_pkg::REG_ROT_R: rot_q[0] <= cfg_wdata;
				qrot_pkg::REG_ROT_I: rot_q[1] <= cfg_wdata;
				qrot_pkg::REG_ROT_J: rot_q[2] <= cfg_wdata;
				qrot_pkg::REG_ROT_K: rot_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic [2*RW-1:0] sq [4];
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sq[i] = (2*RW)'(rot_q[i]) * (2*RW)'(rot_q[i]);
		end
	end

	always_ff @(posedge clk) begin
		norm_q <= NW'(sq[0]) + NW'(sq[1]) + NW'(sq[2]) + NW'(sq[3]);
	end

	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	logic signed [DW-1:0] q_in [4];
	logic signed [RW:0]   conj [4];
	logic signed [MW-1:0] m [4];
	logic signed [TW-1:0] t [4];
	logic        [DW-1:0] res [4];
	logic        [3:0]    clip;

	assign q_in[0] = in_r;
	assign q_in[1] = in_i;
	assign q_in[2] = in_j;
	assign q_in[3] = in_k;

	assign conj[0] = (RW+1)'(rot_q[0]);
	assign conj[1] = -((RW+1)'(rot_q[1]));
	assign conj[2] = -((RW+1)'(rot_q[2]));
	assign conj[3] = -((RW+1)'(rot_q[3]));

	qrot_hamilton #(.AW(RW), .BW(DW), .ZW(MW)) u_pq (
		.clk (clk),
		.en  (en),
		.a   (rot_q),
		.b   (q_in),
		.z   (m)
	);

	qrot_hamilton #(.AW(MW), .BW(RW + 1), .ZW(TW)) u_mc (
		.clk (clk),
		.en  (en),
		.a   (m),
		.b   (conj),
		.z   (t)
	);

	for (genvar c = 0; c < 4; c++) begin : g_div
		qrot_div #(.DW(DW), .TW(TW), .NW(NW)) u_div (
			.clk  (clk),
			.en   (en),
			.t    (t[c]),
			.n    (norm_q),
			.res  (res[c]),
			.clip (clip[c])
		);
	end

	assign out_r     = res[0];
	assign out_i     = res[1];
	assign out_j     = res[2];
	assign out_k     = res[3];
	assign zero_norm = norm_q == '0;
	assign clipped   = |clip;

endmodule

>>> tb/qrot_checker.sv
// qrot_checker: predicts and checks every result of quaternion_rotate_core.
// Watches the config port and both channels; depends on qrot_pkg.
module qrot_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [31:0] in_r,
	input  logic signed [31:0] in_i,
	input  logic signed [31:0] in_j,
	input  logic signed [31:0] in_k,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] out_r,
	input  logic signed [31:0] out_i,
	input  logic signed [31:0] out_j,
	input  logic signed [31:0] out_k,
	input  logic               zero_norm,
	input  logic               clipped,
	input  logic               cfg_we,
	input  logic [qrot_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [17:0]        cfg_wdata,
	output int                 pending,
	output int                 errors,
	output int                 rotated,
	output int                 clip_seen,
	output int                 zero_seen
);

	typedef struct {
		logic signed [31:0] r, i, j, k;
		logic               zn, clip;
	} rot_res_t;

	typedef struct {
		logic signed [127:0] r, i, j, k;
	} wide_quat_t;

	logic signed [17:0] rot_r, rot_i, rot_j, rot_k;
	rot_res_t expected_rot[$];

	function automatic wide_quat_t hprod(input wide_quat_t x, input wide_quat_t y);
		wide_quat_t z;
		z.r = x.r*y.r - x.i*y.i - x.j*y.j - x.k*y.k;
		z.i = x.r*y.i + x.i*y.r + x.j*y.k - x.k*y.j;
		z.j = x.r*y.j + x.j*y.r + x.k*y.i - x.i*y.k;
		z.k = x.r*y.k + x.k*y.r + x.i*y.j - x.j*y.i;
		return z;
	endfunction

	// rounded T/N with ties away from zero, saturated to 32 bits
	function automatic logic signed [31:0] scale_comp(input logic signed [127:0] t,
			input logic signed [127:0] n, inout logic clip);
		logic [127:0] mag, quo, lim;
		mag = (t < 0) ? -t : t;
		quo = (2*mag + n) / (2*n);
		lim = (t < 0) ? 128'h8000_0000 : 128'h7fff_ffff;
		if (quo > lim) begin
			quo  = lim;
			clip = 1'b1;
		end
		return (t < 0) ? -quo[31:0] : quo[31:0];
	endfunction

	function automatic rot_res_t rotate_by_cfg(input logic signed [31:0] qr, qi, qj, qk);
		wide_quat_t p, c, q, t;
		logic signed [127:0] n;
		rot_res_t res;
		p.r = rot_r; p.i = rot_i; p.j = rot_j; p.k = rot_k;
		q.r = qr; q.i = qi; q.j = qj; q.k = qk;
		c.r = p.r; c.i = -p.i; c.j = -p.j; c.k = -p.k;
		n = p.r*p.r + p.i*p.i + p.j*p.j + p.k*p.k;
		res = '{default: '0};
		if (n == 0) begin
			res.zn = 1'b1;
			return res;
		end
		t = hprod(hprod(p, q), c);
		res.r = scale_comp(t.r, n, res.clip);
		res.i = scale_comp(t.i, n, res.clip);
		res.j = scale_comp(t.j, n, res.clip);
		res.k = scale_comp(t.k, n, res.clip);
		return res;
	endfunction

	task automatic report(input string what, input logic signed [31:0] got, exp_v);
		errors++;
		$display("MISMATCH %s: got %0d, expected %0d (beat %0d)", what, got, exp_v, rotated);
	endtask

	initial begin
		errors    = 0;
		pending   = 0;
		rotated   = 0;
		clip_seen = 0;
		zero_seen = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		rot_res_t e;
		if (!arst_n) begin
			rot_r <= qrot_pkg::ROT_R_RESET[17:0];
			rot_i <= '0;
			rot_j <= '0;
			rot_k <= '0;
		end else begin
			if (in_valid && in_ready)
				expected_rot.push_back(rotate_by_cfg(in_r, in_i, in_j, in_k));
			if (out_valid && out_ready) begin
				if (expected_rot.size() == 0) begin
					errors++;
					$display("MISMATCH: result beat with nothing outstanding");
				end else begin
					e = expected_rot.pop_front();
					if (out_r !== e.r) report("out_r", out_r, e.r);
					if (out_i !== e.i) report("out_i", out_i, e.i);
					if (out_j !== e.j) report("out_j", out_j, e.j);
					if (out_k !== e.k) report("out_k", out_k, e.k);
					if (zero_norm !== e.zn) report("zero_norm", zero_norm, e.zn);
					if (clipped !== e.clip) report("clipped", clipped, e.clip);
					if (e.clip) clip_seen++;
					if (e.zn) zero_seen++;
					rotated++;
				end
			end
			pending = expected_rot.size();
			if (cfg_we) begin
				case (cfg_addr)
					qrot_pkg::REG_ROT_R: rot_r <= cfg_wdata;
					qrot_pkg::REG_ROT_I: rot_i <= cfg_wdata;
					qrot_pkg::REG_ROT_J: rot_j <= cfg_wdata;
					qrot_pkg::REG_ROT_K: rot_k <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

endmodule

>>> tb/tb_quaternion_rotate_core.sv
// tb_quaternion_rotate_core: stimulus and verdict for quaternion_rotate_core.
// Drives config writes and quaternion beats with random idling; qrot_checker compares.
module tb_quaternion_rotate_core;

	localparam int DW = qrot_pkg::DATA_WIDTH_DEF;
	localparam int LAT = DW + 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, out_ready = 1'b0, cfg_we = 1'b0;
	logic in_ready, out_valid, zero_norm, clipped;
	logic signed [31:0] in_r = '0, in_i = '0, in_j = '0, in_k = '0;
	logic signed [31:0] out_r, out_i, out_j, out_k;
	logic [qrot_pkg::CFG_ADDR_W-1:0] cfg_addr = qrot_pkg::REG_ROT_R;
	logic [17:0] cfg_wdata = '0;
	int pending, errors, rotated, clip_seen, zero_seen;
	bit stalls_on = 1'b1;
	bit long_hold = 1'b0;

	always #5 clk = ~clk;

	quaternion_rotate_core i_dut (.*);

	qrot_checker i_checker (.*);

	// receiver: ready bursts, random stall bursts, one long hold on request
	initial begin
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (200) @(posedge clk);
				long_hold = 1'b0;
			end else if (stalls_on && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	task automatic write_reg(input logic [qrot_pkg::CFG_ADDR_W-1:0] idx,
			input logic [17:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (LAT + 4) @(posedge clk);
	endtask

	task automatic set_rot(input logic [17:0] r, i, j, k);
		drain();
		write_reg(qrot_pkg::REG_ROT_R, r);
		write_reg(qrot_pkg::REG_ROT_I, i);
		write_reg(qrot_pkg::REG_ROT_J, j);
		write_reg(qrot_pkg::REG_ROT_K, k);
	endtask

	task automatic send_quat(input logic signed [31:0] r, i, j, k);
		if (stalls_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_r <= r;
		in_i <= i;
		in_j <= j;
		in_k <= k;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_comp();
		case ($urandom_range(0, 7))
			0:       return 32'sh7fff_ffff;
			1:       return 32'sh8000_0000;
			2:       return '0;
			3, 4:    return $signed($urandom_range(0, 2**21)) - 32'sd1048576;
			default: return $urandom;
		endcase
	endfunction

	task automatic rand_beats(input int count);
		repeat (count) begin
			if ($urandom_range(0, 3) == 0)
				send_quat('0, rand_comp(), rand_comp(), rand_comp());
			else
				send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
		end
	endtask

	task automatic edge_beats();
		send_quat('0, '0, '0, '0);
		send_quat(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
		send_quat(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		send_quat(-32'sd1, -32'sd1, -32'sd1, -32'sd1);
		send_quat('0, 32'sd65536, 32'sd131072, 32'sd196608);
		send_quat(32'sd1, -32'sd1, 32'sh7fff_ffff, 32'sh8000_0000);
	endtask

	initial begin
		#2_000_000;
		$display("timeout: %0d results outstanding", pending);
		$display("tb_quaternion_rotate_core: done, errors");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unit p after reset, half turn about i, extreme p, zero p
		edge_beats();
		set_rot(18'sd0, 18'sd65536, 18'sd0, 18'sd0);
		edge_beats();
		set_rot(18'h1ffff, 18'h20000, 18'h1ffff, 18'h20000);
		edge_beats();
		set_rot('0, '0, '0, '0);
		send_quat(32'sd5, 32'sd6, 32'sd7, 32'sd8);
		send_quat(32'sh7fff_ffff, 32'sh8000_0000, '0, -32'sd1);

		// random beats, p at the negative extreme on every register, then p.r = 1
		set_rot(18'h20000, 18'h20000, 18'h20000, 18'h20000);
		rand_beats(60);
		set_rot(18'sd1, '0, '0, '0);
		rand_beats(60);

		// long receiver hold while the sender keeps offering back to back
		set_rot(18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom));
		stalls_on = 1'b0;
		long_hold = 1'b1;
		rand_beats(80);
		stalls_on = 1'b1;
		drain();
		rand_beats(30);

		repeat (4) begin
			set_rot(18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom));
			rand_beats(55);
		end
		set_rot(18'($urandom_range(0, 255)), 18'(18'h3ff00 | $urandom_range(0, 255)),
			18'($urandom_range(0, 3)), 18'h3ffff);
		rand_beats(50);

		set_rot(18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom));
		stalls_on = 1'b0;
		rand_beats(70);
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (LAT + 10) @(posedge clk);

		$display("%0d rotations checked over thirteen rotation settings", rotated);
		$display("%0d saturated results, %0d with zero rotation", clip_seen, zero_seen);
		if (errors == 0)
			$display("tb_quaternion_rotate_core: done, clean");
		else
			$display("tb_quaternion_rotate_core: done, errors");
		$finish;
	end

endmodule

>>> quaternion_rotate_core.f
hw/rtl/qrot_pkg.sv
hw/rtl/qrot_hamilton.sv
hw/rtl/qrot_div.sv
hw/rtl/quaternion_rotate_core.sv
tb/qrot_checker.sv
tb/tb_quaternion_rotate_core.sv
